[rtl/mlfc_pkg.sv]
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types, constants and helpers of the memory LCD frame controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfc_pkg;

  // panel geometry
  localparam int PANEL_WIDTH  = 144;
  localparam int PANEL_HEIGHT = 168;

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
  localparam int ROW_BYTES   = PANEL_WIDTH / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int ROW_CNT_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int PX_W        = $clog2(PANEL_WIDTH);
  localparam int PY_W        = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int LIN_W       = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
  localparam int QUEUE_DEPTH = 2;

  // panel command byte bits
  localparam logic [7:0] BIT_WRITE = 8'h80;
  localparam logic [7:0] BIT_VCOM  = 8'h40;
  localparam logic [7:0] BIT_CLEAR = 8'h20;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FILL = 8'hff;

  // result kinds
  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_LINE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WR_MOD,
    ST_RD_OUT,
    ST_CLR_CMD,
    ST_CLR_TRL,
    ST_CLR_FILL,
    ST_LN_CMD,
    ST_LN_ADDR,
    ST_LN_DATA,
    ST_LN_TRL,
    ST_LN_EXTRA
  } back_state_e;

  // classified operation passed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic              oob;
    logic              pixel_on;
    logic [2:0]        bit_sel;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        line;
  } mlfc_op_t;

  // bit reversal for lsb-first store bytes shifted out msb first
  function automatic logic [7:0] rev8(input logic [7:0] d);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = d[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/mlfc_front.sv]
// ----------------------------------------------------------------------------
// mlfc_front
// Accepts requests, holds the rotation register, checks bounds and maps
// logical points to store byte and bit; drops requests with no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_front import mlfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_rotation_i,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [8:0] pos_x_i,
  input  wire logic [8:0] pos_y_i,
  input  wire logic       pixel_on_i,
  input  wire logic [7:0] line_index_i,
  // towards the queue
  input  wire logic       q_full_i,
  input  wire logic       init_busy_i,
  output logic            push_o,
  output mlfc_op_t        op_o
);

  localparam logic [9:0] PW = 10'(PANEL_WIDTH);
  localparam logic [9:0] PH = 10'(PANEL_HEIGHT);

  rot_e              rotation_q;
  cmd_e              cmd;
  logic [9:0]        x_w, y_w, lw, lh, px_w, py_w;
  logic [PX_W-1:0]   px;
  logic [PY_W-1:0]   py;
  logic [LIN_W-1:0]  lin, idx_full;
  logic              hit, line_ok, keep;
  logic [ADDR_W-1:0] base;

  // rotation register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (cfg_valid_i) begin
      rotation_q <= rot_e'(cfg_rotation_i);
    end
  end

  // rotated bounds and panel point
  always_comb begin
    cmd = cmd_e'(cmd_i);
    x_w = {1'b0, pos_x_i};
    y_w = {1'b0, pos_y_i};
    lw  = rotation_q[0] ? PH : PW;
    lh  = rotation_q[0] ? PW : PH;
    case (rotation_q)
      ROT_90: begin
        px_w = PW - 10'd1 - y_w;
        py_w = x_w;
      end
      ROT_180: begin
        px_w = PW - 10'd1 - x_w;
        py_w = PH - 10'd1 - y_w;
      end
      ROT_270: begin
        px_w = y_w;
        py_w = PH - 10'd1 - x_w;
      end
      default: begin
        px_w = x_w;
        py_w = y_w;
      end
    endcase
  end

  assign px       = px_w[PX_W-1:0];
  assign py       = py_w[PY_W-1:0];
  assign lin      = LIN_W'(py) * LIN_W'(PANEL_WIDTH) + LIN_W'(px);
  assign idx_full = lin >> 3;
  assign hit      = (x_w < lw) && (y_w < lh) && (idx_full < LIN_W'(STORE_BYTES));

  // row start for send line
  assign line_ok = {1'b0, line_index_i} < 9'(PANEL_HEIGHT);
  assign base    = ADDR_W'(line_index_i) * ADDR_W'(ROW_BYTES);

  // classification
  always_comb begin
    op_o          = '0;
    op_o.cmd      = cmd;
    op_o.oob      = !hit;
    op_o.pixel_on = pixel_on_i;
    op_o.bit_sel  = px[2:0];
    op_o.line     = line_index_i;
    case (cmd)
      CMD_WRITE: begin
        op_o.addr = idx_full[ADDR_W-1:0];
        keep      = hit;
      end
      CMD_READ: begin
        op_o.addr = idx_full[ADDR_W-1:0];
        keep      = 1'b1;
      end
      CMD_LINE: begin
        op_o.addr = base;
        keep      = line_ok;
      end
      default: begin
        op_o.addr = '0;
        keep      = 1'b1;
      end
    endcase
  end

  assign in_stall_o = q_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o && keep;

endmodule

`default_nettype wire

[rtl/mlfc_queue.sv]
// ----------------------------------------------------------------------------
// mlfc_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_queue import mlfc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  mlfc_op_t      op_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output mlfc_op_t      head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mlfc_op_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

[rtl/mlfc_back.sv]
// ----------------------------------------------------------------------------
// mlfc_back
// Executes queued operations on the frame store and drives the result
// register: pixel read-modify-write, pixel read, clear with fill pass and
// line streaming at one byte per cycle unless the result side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_back import mlfc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // queue side
  input  wire logic     q_empty_i,
  input  mlfc_op_t      head_i,
  output logic          pop_o,
  output logic          init_busy_o,
  // result channel
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output logic          kind_o,
  output logic [7:0]    data_byte_o,
  output logic          last_o
);

  back_state_e          state_q, state_d;
  mlfc_op_t             op_q, op_d;
  logic                 vcom_q, vcom_d;
  logic [ADDR_W-1:0]    fill_q, fill_d;
  logic [ADDR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ROW_CNT_W-1:0] cnt_q, cnt_d;

  logic [7:0]           frame_mem_q [STORE_BYTES];
  logic [7:0]           rdata_q;
  logic                 mem_we, rd_en;
  logic [ADDR_W-1:0]    wa, ra;
  logic [7:0]           wd;

  logic                 out_valid_q, out_kind_q, out_last_q;
  logic [7:0]           out_data_q;
  logic                 emit, emit_kind, emit_last, out_free, fire;
  logic [7:0]           emit_data, vcom_byte, mod_byte;
  logic                 fill_done, row_done, final_row;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = emit && out_free;
  assign fill_done = (fill_q == ADDR_W'(STORE_BYTES - 1));
  assign row_done  = (cnt_q == ROW_CNT_W'(ROW_BYTES - 1));
  assign final_row = (op_q.line == 8'(PANEL_HEIGHT - 1));
  assign vcom_byte = vcom_q ? BIT_VCOM : BYTE_ZERO;

  // pixel modify
  always_comb begin
    mod_byte = rdata_q;
    mod_byte[op_q.bit_sel] = op_q.pixel_on;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (fill_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (head_i.cmd)
            CMD_WRITE: state_d = ST_WR_MOD;
            CMD_READ:  state_d = ST_RD_OUT;
            CMD_CLEAR: state_d = ST_CLR_CMD;
            default:   state_d = (head_i.line == 8'd0) ? ST_LN_CMD : ST_LN_ADDR;
          endcase
        end
      end
      ST_WR_MOD:   state_d = ST_IDLE;
      ST_RD_OUT: begin
        if (fire) state_d = ST_IDLE;
      end
      ST_CLR_CMD: begin
        if (fire) state_d = ST_CLR_TRL;
      end
      ST_CLR_TRL: begin
        if (fire) state_d = ST_CLR_FILL;
      end
      ST_CLR_FILL: begin
        if (fill_done) state_d = ST_IDLE;
      end
      ST_LN_CMD: begin
        if (fire) state_d = ST_LN_ADDR;
      end
      ST_LN_ADDR: begin
        if (fire) state_d = ST_LN_DATA;
      end
      ST_LN_DATA: begin
        if (fire && row_done) state_d = ST_LN_TRL;
      end
      ST_LN_TRL: begin
        if (fire) state_d = final_row ? ST_LN_EXTRA : ST_IDLE;
      end
      ST_LN_EXTRA: begin
        if (fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    pop_o     = 1'b0;
    op_d      = op_q;
    vcom_d    = vcom_q;
    fill_d    = fill_q;
    rd_ptr_d  = rd_ptr_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    wa        = fill_q;
    wd        = BYTE_FILL;
    rd_en     = 1'b0;
    ra        = rd_ptr_q;
    emit      = 1'b0;
    emit_kind = KIND_SERIAL;
    emit_data = BYTE_ZERO;
    emit_last = 1'b0;
    case (state_q)
      ST_INIT, ST_CLR_FILL: begin
        mem_we = 1'b1;
        fill_d = fill_q + 1'b1;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o    = 1'b1;
          op_d     = head_i;
          rd_ptr_d = head_i.addr;
          ra       = head_i.addr;
          rd_en    = ((head_i.cmd == CMD_WRITE) || (head_i.cmd == CMD_READ)) && !head_i.oob;
        end
      end
      ST_WR_MOD: begin
        mem_we = 1'b1;
        wa     = op_q.addr;
        wd     = mod_byte;
      end
      ST_RD_OUT: begin
        emit      = 1'b1;
        emit_kind = KIND_READ;
        emit_data = op_q.oob ? BYTE_ZERO : {7'd0, rdata_q[op_q.bit_sel]};
        emit_last = 1'b1;
      end
      ST_CLR_CMD: begin
        emit      = 1'b1;
        emit_data = BIT_CLEAR | vcom_byte;
        if (fire) vcom_d = !vcom_q;
      end
      ST_CLR_TRL: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        fill_d    = '0;
      end
      ST_LN_CMD: begin
        emit      = 1'b1;
        emit_data = BIT_WRITE | vcom_byte;
        if (fire) vcom_d = !vcom_q;
      end
      ST_LN_ADDR: begin
        emit      = 1'b1;
        emit_data = rev8(op_q.line + 8'd1);
        if (fire) begin
          rd_en    = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
          cnt_d    = '0;
        end
      end
      ST_LN_DATA: begin
        emit      = 1'b1;
        emit_data = rev8(rdata_q);
        if (fire && !row_done) begin
          rd_en    = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      ST_LN_TRL: begin
        emit      = 1'b1;
        emit_last = !final_row;
      end
      ST_LN_EXTRA: begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      vcom_q      <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcom_q      <= vcom_d;
      fill_q      <= fill_d;
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  // operation and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    rd_ptr_q <= rd_ptr_d;
    cnt_q    <= cnt_d;
    if (fire) begin
      out_kind_q <= emit_kind;
      out_data_q <= emit_data;
      out_last_q <= emit_last;
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= frame_mem_q[ra];
    end
  end

  assign init_busy_o = (state_q == ST_INIT);
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign data_byte_o = out_data_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

[rtl/memory_lcd_frame_controller_unit.sv]
// ----------------------------------------------------------------------------
// memory_lcd_frame_controller_unit
// Frame store and serial byte sequencer for a 144x168 memory-in-pixel LCD.
// ----------------------------------------------------------------------------
// Request channel (in_valid_i / in_stall_o) takes pixel write, pixel read,
// clear and send-line commands; the result channel (out_valid_o /
// out_stall_i) returns panel bytes (kind 0) and read answers (kind 1), with
// last_o marking the final result of each request. The rotation register
// is written over cfg_valid_i / cfg_ready_o; the user must write it only
// while the block is idle, which the block itself does not enforce.
// A front stage classifies each request and places it in a two-entry queue;
// the back engine works through the queue one operation at a time, picking
// each one up in its idle state.
// Pixel write: store read, then modify and write back. Pixel read: store
// read, then the answer goes to the result register. Send line: one byte
// per cycle while the result side does not stall, 20 bytes (21 for the
// first and last row). Clear: two bytes, then a fill pass over all 3024
// store bytes. The throughput is set by the frame store and back engine.
// After reset the store is filled with ones, with in_stall_o high. A stall
// on the result side holds the result register and stops the engine; the
// queue still takes requests until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_lcd_frame_controller_unit import mlfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_rotation_i,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [8:0] pos_x_i,
  input  wire logic [8:0] pos_y_i,
  input  wire logic       pixel_on_i,
  input  wire logic [7:0] line_index_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o
);

  mlfc_op_t push_op, head_op;
  logic     push, pop, q_full, q_empty, init_busy;

  // request classification
  mlfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_rotation_i (cfg_rotation_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pixel_on_i     (pixel_on_i),
    .line_index_i   (line_index_i),
    .q_full_i       (q_full),
    .init_busy_i    (init_busy),
    .push_o         (push),
    .op_o           (push_op)
  );

  // decoupling queue
  mlfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_op)
  );

  // execution engine and frame store
  mlfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_op),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

[rtl/mlfc_checker.sv]
// ----------------------------------------------------------------------------
// mlfc_checker
// Port-level checks of the frame controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic [1:0] cfg_rotation_i,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] cmd_i,
  input wire logic [8:0] pos_x_i,
  input wire logic [8:0] pos_y_i,
  input wire logic       pixel_on_i,
  input wire logic [7:0] line_index_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       kind_o,
  input wire logic [7:0] data_byte_o,
  input wire logic       last_o
);

  // a stalled result stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(data_byte_o) && $stable(kind_o) && $stable(last_o))
    else $error("stalled result changed");

  // a read answer is always the only result of its request
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("read answer without last");

  // a read answer carries a single bit
  a_read_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> data_byte_o[7:1] == 7'd0)
    else $error("read answer wider than one bit");

  // every serial sequence ends in a zero trailer byte
  a_serial_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o && last_o |-> data_byte_o == 8'h00)
    else $error("serial sequence ends in a non-zero byte");

endmodule

bind memory_lcd_frame_controller_unit mlfc_checker u_mlfc_checker (.*);

`default_nettype wire
